[rtl/edpa_pkg.sv]
// ---------------------------------------------------------------------------
// edpa_pkg
// Shared widths, codes and constants of the exact double product accumulator.
// ---------------------------------------------------------------------------
package edpa_pkg;

  localparam int OP_W     = 64;   // raw binary64 pattern
  localparam int SIG_W    = 53;   // significand with hidden bit
  localparam int EXP_W    = 12;   // unbiased exponent, signed
  localparam int LIMB_W   = 32;   // magnitude limb width
  localparam int ACC_W    = 64;   // stored limb width
  localparam int IDX_W    = 8;    // reported limb index width
  localparam int CHUNKS   = 5;    // limbs touched by one product
  localparam int PROD_W   = 2 * SIG_W;
  localparam int POS_W    = 16;   // bit position inside the accumulator

  localparam logic [10:0]           EXP_FIELD_MAX = 11'h7FF;
  localparam logic signed [EXP_W-1:0] EXP_BIAS    = 12'sd1075;
  localparam logic signed [EXP_W-1:0] SUBN_EXP    = -12'sd1074;

  // result sign codes
  localparam logic signed [1:0] SIGN_ZERO = 2'sb00;
  localparam logic signed [1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [1:0] SIGN_NEG  = 2'sb11;

endpackage

[rtl/edpa_in_if.sv]
// ---------------------------------------------------------------------------
// edpa_in_if
// Term channel: two binary64 factors and control flags.
// ---------------------------------------------------------------------------
interface edpa_in_if
  import edpa_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] first_operand;
  logic [OP_W-1:0] second_operand;
  logic            negate;
  logic            clear_first;
  logic            emit_after;

  modport source (output valid, first_operand, second_operand, negate, clear_first,
                  emit_after, input ready);
  modport sink   (input valid, first_operand, second_operand, negate, clear_first,
                  emit_after, output ready);
endinterface

[rtl/edpa_out_if.sv]
// ---------------------------------------------------------------------------
// edpa_out_if
// Result channel: sign, top limb index and the three top magnitude limbs.
// ---------------------------------------------------------------------------
interface edpa_out_if
  import edpa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic signed [1:0]   result_sign;
  logic [IDX_W-1:0]    top_limb_index;
  logic [LIMB_W-1:0]   limb_high;
  logic [LIMB_W-1:0]   limb_middle;
  logic [LIMB_W-1:0]   limb_low;
  logic                range_error;

  modport source (output valid, result_sign, top_limb_index, limb_high, limb_middle,
                  limb_low, range_error, input ready);
  modport sink   (input valid, result_sign, top_limb_index, limb_high, limb_middle,
                  limb_low, range_error, output ready);
endinterface

[rtl/exact_double_product_accumulator.sv]
// ---------------------------------------------------------------------------
// exact_double_product_accumulator
// Exact long accumulator of binary64 products held in a limb RAM.
// ---------------------------------------------------------------------------
// A finite term passes normalize, multiply through one shared 32x32
// multiplier, align and a limb RAM read-modify-write before idle; a subnormal
// factor stays in normalize until its leading zeros are shifted out, and two
// subnormal factors normalize side by side.
// A readout adds two RAM sweeps.
// The block takes one term at a time. Reset clears the accumulator through one
// valid bit per limb, the range flag and all handshakes at once.
module exact_double_product_accumulator
  import edpa_pkg::*;
#(
  parameter int NUM_LIMBS           = 176,
  parameter int LOWEST_BIT_EXPONENT = -2464
) (
  input  logic       clk,
  input  logic       rst_n,
  edpa_in_if.sink    in_ch,
  edpa_out_if.source out_ch
);
  localparam int ADDR_W = $clog2(NUM_LIMBS);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(NUM_LIMBS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_MUL, ST_SHIFT, ST_RMW, ST_SWEEP_A, ST_SWEEP_B, ST_DONE
  } state_t;

  state_t state_r;

  // operand registers
  logic [SIG_W-1:0]        sig_a_r, sig_b_r;
  logic signed [EXP_W-1:0] exp_a_r, exp_b_r;
  logic                    neg_r, emit_r;

  // multiply and align
  logic [2:0]              mul_step_r;
  logic [2*LIMB_W-1:0]     pp_r;
  logic [1:0]              pp_sh_r;
  logic                    pp_v_r, pp_last_r;
  logic [PROD_W-1:0]       prod_r;
  logic [ADDR_W-1:0]       base_r;
  logic [4:0]              sh_r;
  logic [CHUNKS*LIMB_W-1:0] chunks_r;

  // RAM access pipeline
  logic [2:0]              k_r;
  logic                    rd_v_r, rd_hit_r;
  logic [ADDR_W-1:0]       rd_idx_r;
  logic [2:0]              rd_k_r;
  logic [NUM_LIMBS-1:0]    valid_r;
  logic                    range_r;

  // readout sweeps
  logic [ADDR_W-1:0]       scan_r;
  logic                    scan_end_r;
  logic [LIMB_W-1:0]       carry_a_r, carry1_r, carry2_r;
  logic                    sign_neg_r;
  logic [ACC_W-1:0]        v_r;
  logic [ADDR_W-1:0]       v_idx_r;
  logic                    v_v_r;
  logic                    found_r;
  logic [ADDR_W-1:0]       top_r;
  logic [LIMB_W-1:0]       lh_r, lm_r, ll_r, prev1_r, prev2_r;

  // output register
  logic                    out_valid_r;
  logic signed [1:0]       out_sign_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [LIMB_W-1:0]       out_lh_r, out_lm_r, out_ll_r;
  logic                    out_rng_r;

  // RAM ports
  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [ACC_W-1:0]        ram_wdata, ram_rdata, rd_data;

  // operand decode
  logic [10:0]             fld_a, fld_b;
  logic [51:0]             frac_a, frac_b;
  logic                    ok_a, ok_b;
  logic [SIG_W-1:0]        dsig_a, dsig_b;
  logic signed [EXP_W-1:0] dexp_a, dexp_b;

  // placement
  logic signed [POS_W-1:0] pos;
  logic                    out_of_range;

  // multiplier operands
  logic [LIMB_W-1:0]       mul_a, mul_b;

  // sweep arithmetic
  logic [ACC_W-1:0]        sum_a, sum1, sum2, mag;

  logic in_xfer;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // split both raw patterns into significand and exponent
  always_comb begin
    fld_a  = in_ch.first_operand[62:52];
    fld_b  = in_ch.second_operand[62:52];
    frac_a = in_ch.first_operand[51:0];
    frac_b = in_ch.second_operand[51:0];
    ok_a   = (fld_a != EXP_FIELD_MAX) && !((fld_a == 11'd0) && (frac_a == 52'd0));
    ok_b   = (fld_b != EXP_FIELD_MAX) && !((fld_b == 11'd0) && (frac_b == 52'd0));
    dsig_a = {(fld_a != 11'd0), frac_a};
    dsig_b = {(fld_b != 11'd0), frac_b};
    dexp_a = (fld_a == 11'd0) ? SUBN_EXP : $signed({1'b0, fld_a}) - EXP_BIAS;
    dexp_b = (fld_b == 11'd0) ? SUBN_EXP : $signed({1'b0, fld_b}) - EXP_BIAS;
  end

  // product placement and range check
  always_comb begin
    pos = POS_W'(exp_a_r) + POS_W'(exp_b_r) - POS_W'(LOWEST_BIT_EXPONENT);
    out_of_range = pos[POS_W-1] ||
                   ((11'({1'b0, pos[14:5]}) + 11'd5) >= 11'(NUM_LIMBS));
  end

  // partial product operand select
  always_comb begin
    unique case (mul_step_r[1:0])
      2'd0:    begin mul_a = sig_a_r[31:0];               mul_b = sig_b_r[31:0]; end
      2'd1:    begin mul_a = sig_a_r[31:0];               mul_b = 32'(sig_b_r[52:32]); end
      2'd2:    begin mul_a = 32'(sig_a_r[52:32]);          mul_b = sig_b_r[31:0]; end
      default: begin mul_a = 32'(sig_a_r[52:32]);          mul_b = 32'(sig_b_r[52:32]); end
    endcase
  end

  // RAM read issue and write back
  always_comb begin
    rd_data   = rd_hit_r ? ram_rdata : '0;
    ram_re    = 1'b0;
    ram_raddr = scan_r;
    ram_we    = 1'b0;
    ram_waddr = rd_idx_r;
    ram_wdata = neg_r ? rd_data - ACC_W'(chunks_r[rd_k_r*LIMB_W +: LIMB_W])
                      : rd_data + ACC_W'(chunks_r[rd_k_r*LIMB_W +: LIMB_W]);
    if (state_r == ST_RMW) begin
      ram_re    = (k_r < 3'(CHUNKS));
      ram_raddr = base_r + ADDR_W'(k_r);
      ram_we    = rd_v_r;
    end else if (state_r == ST_SWEEP_A || state_r == ST_SWEEP_B) begin
      ram_re    = !scan_end_r;
    end
  end

  // carry propagation for both sweeps
  always_comb begin
    sum_a = rd_data + {{LIMB_W{carry_a_r[LIMB_W-1]}}, carry_a_r};
    sum1  = rd_data + {{LIMB_W{carry1_r[LIMB_W-1]}}, carry1_r};
    sum2  = {{LIMB_W{carry2_r[LIMB_W-1]}}, carry2_r} - v_r;
    if (!sign_neg_r) begin
      mag = v_r;
    end else if (v_idx_r == LAST) begin
      mag = sum2;
    end else begin
      mag = {{LIMB_W{1'b0}}, sum2[LIMB_W-1:0]};
    end
  end

  edpa_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NUM_LIMBS)
  ) u_limbs (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      range_r     <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      pp_v_r      <= 1'b0;
      v_v_r       <= 1'b0;
      scan_end_r  <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      rd_v_r   <= ram_re;
      rd_idx_r <= ram_raddr;
      rd_hit_r <= valid_r[ram_raddr];
      rd_k_r   <= k_r;

      // sweep counters rest at zero outside the readout
      if (state_r != ST_SWEEP_A && state_r != ST_SWEEP_B) begin
        scan_r     <= '0;
        scan_end_r <= 1'b0;
        carry_a_r  <= '0;
      end else if (!scan_end_r) begin
        scan_end_r <= (scan_r == LAST);
        scan_r     <= (scan_r == LAST) ? scan_r : scan_r + 1'b1;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.clear_first) begin
              valid_r <= '0;
              range_r <= 1'b0;
            end
            sig_a_r <= dsig_a;
            sig_b_r <= dsig_b;
            exp_a_r <= dexp_a;
            exp_b_r <= dexp_b;
            neg_r   <= in_ch.negate ^ in_ch.first_operand[63] ^ in_ch.second_operand[63];
            emit_r  <= in_ch.emit_after;
            if (ok_a && ok_b) begin
              state_r <= ST_NORM;
            end else if (in_ch.emit_after) begin
              state_r <= ST_SWEEP_A;
            end
          end
        end

        // subnormal factors shift up one bit a cycle
        ST_NORM: begin
          if (!sig_a_r[SIG_W-1]) begin
            sig_a_r <= sig_a_r << 1;
            exp_a_r <= exp_a_r - EXP_W'(1);
          end
          if (!sig_b_r[SIG_W-1]) begin
            sig_b_r <= sig_b_r << 1;
            exp_b_r <= exp_b_r - EXP_W'(1);
          end
          if (sig_a_r[SIG_W-1] && sig_b_r[SIG_W-1]) begin
            base_r     <= ADDR_W'(pos[14:5]);
            sh_r       <= pos[4:0];
            mul_step_r <= '0;
            prod_r     <= '0;
            if (out_of_range) begin
              range_r <= 1'b1;
              state_r <= emit_r ? ST_SWEEP_A : ST_IDLE;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end

        // four partial products, each registered before accumulation
        ST_MUL: begin
          pp_v_r <= (mul_step_r < 3'd4);
          if (mul_step_r < 3'd4) begin
            pp_r       <= mul_a * mul_b;
            pp_sh_r    <= (mul_step_r == 3'd0) ? 2'd0 : (mul_step_r == 3'd3) ? 2'd2 : 2'd1;
            pp_last_r  <= (mul_step_r == 3'd3);
            mul_step_r <= mul_step_r + 1'b1;
          end
          if (pp_v_r) begin
            prod_r <= prod_r + (PROD_W'(pp_r) << (LIMB_W * pp_sh_r));
            if (pp_last_r) begin
              state_r <= ST_SHIFT;
            end
          end
        end

        ST_SHIFT: begin
          pp_v_r   <= 1'b0;
          chunks_r <= (CHUNKS*LIMB_W)'(prod_r) << sh_r;
          k_r      <= '0;
          state_r  <= ST_RMW;
        end

        // five limbs read, added and written back in a row
        ST_RMW: begin
          if (k_r < 3'(CHUNKS)) begin
            k_r <= k_r + 1'b1;
          end
          if (rd_v_r && rd_k_r == 3'(CHUNKS - 1)) begin
            state_r <= emit_r ? ST_SWEEP_A : ST_IDLE;
          end
        end

        // first sweep: carries up to the top limb give the sign
        ST_SWEEP_A: begin
          if (rd_v_r) begin
            carry_a_r <= sum_a[ACC_W-1:LIMB_W];
            if (rd_idx_r == LAST) begin
              sign_neg_r <= sum_a[ACC_W-1];
              scan_r     <= '0;
              scan_end_r <= 1'b0;
              carry1_r   <= '0;
              carry2_r   <= '0;
              v_v_r      <= 1'b0;
              found_r    <= 1'b0;
              top_r      <= '0;
              lh_r       <= '0;
              lm_r       <= '0;
              ll_r       <= '0;
              prev1_r    <= '0;
              prev2_r    <= '0;
              state_r    <= ST_SWEEP_B;
            end
          end
        end

        // second sweep: carries again, negate if needed, track top limbs
        ST_SWEEP_B: begin
          v_v_r <= rd_v_r;
          if (rd_v_r) begin
            carry1_r <= sum1[ACC_W-1:LIMB_W];
            v_r      <= (rd_idx_r == LAST) ? sum1 : {{LIMB_W{1'b0}}, sum1[LIMB_W-1:0]};
            v_idx_r  <= rd_idx_r;
          end
          if (v_v_r) begin
            carry2_r <= sum2[ACC_W-1:LIMB_W];
            prev1_r  <= mag[LIMB_W-1:0];
            prev2_r  <= prev1_r;
            if (mag != '0) begin
              found_r <= 1'b1;
              top_r   <= v_idx_r;
              lh_r    <= mag[LIMB_W-1:0];
              lm_r    <= prev1_r;
              ll_r    <= prev2_r;
            end
            if (v_idx_r == LAST) begin
              state_r <= ST_DONE;
            end
          end
        end

        // hand the result to the output register
        ST_DONE: begin
          v_v_r <= 1'b0;
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sign_r  <= !found_r ? SIGN_ZERO : sign_neg_r ? SIGN_NEG : SIGN_POS;
            out_idx_r   <= IDX_W'(top_r);
            out_lh_r    <= lh_r;
            out_lm_r    <= lm_r;
            out_ll_r    <= ll_r;
            out_rng_r   <= range_r;
            state_r     <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_sign    = out_sign_r;
  assign out_ch.top_limb_index = out_idx_r;
  assign out_ch.limb_high      = out_lh_r;
  assign out_ch.limb_middle    = out_lm_r;
  assign out_ch.limb_low       = out_ll_r;
  assign out_ch.range_error    = out_rng_r;

endmodule

[rtl/edpa_ram.sv]
// ---------------------------------------------------------------------------
// edpa_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module edpa_ram
  import edpa_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = 176
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
